>>> sv/slc_pkg.sv
package slc_pkg;

	// Storage geometry
	localparam int MAX_SHARDS = 64;
	localparam int SHARD_W    = 6;
	localparam int COUNT_W    = 32;
	localparam int ACT_W      = 7;
	localparam int TOTAL_W    = 32;

	// Configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic [APB_ADDR_W-1:0] REG_ACTIVE_SHARD_COUNT = 3'd0;

	typedef enum logic [1:0] {
		OP_LIVE  = 2'd0,
		OP_DEAD  = 2'd1,
		OP_QUERY = 2'd2,
		OP_RSVD  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_REJECT    = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_SATURATED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_UPDATE,
		S_QUERY
	} state_t;

endpackage

>>> sv/slc_stream_if.sv
interface slc_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] primary_shard;
	logic [7:0] fallback_shard;

	modport source (output valid, output opcode, output primary_shard,
		output fallback_shard, input ready);
	modport sink (input valid, input opcode, input primary_shard,
		input fallback_shard, output ready);
endinterface

interface slc_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        was_last_task;
	logic [31:0] live_total;
	logic        any_live;
	logic        fatal_seen;

	modport source (output valid, output status, output was_last_task,
		output live_total, output any_live, output fatal_seen, input ready);
	modport sink (input valid, input status, input was_last_task,
		input live_total, input any_live, input fatal_seen, output ready);
endinterface

>>> sv/slc_cfg.sv
module slc_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [slc_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [slc_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [slc_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	output logic [slc_pkg::ACT_W-1:0]       act_eff
);

	logic [slc_pkg::ACT_W-1:0] active_q;
	logic                      wr_hit;

	assign pready = 1'b1;
	assign wr_hit = psel && penable && pwrite && pready &&
		(paddr == slc_pkg::REG_ACTIVE_SHARD_COUNT);

	// Hold the active shard count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (wr_hit) begin
			active_q <= pwdata[slc_pkg::ACT_W-1:0];
		end
	end

	// Read back the register
	always_comb begin
		prdata = '0;
		if (paddr == slc_pkg::REG_ACTIVE_SHARD_COUNT) begin
			prdata = {{(slc_pkg::APB_DATA_W-slc_pkg::ACT_W){1'b0}}, active_q};
		end
	end

	// Clamp to the number of shards actually stored
	assign act_eff = (active_q > slc_pkg::ACT_W'(slc_pkg::MAX_SHARDS)) ?
		slc_pkg::ACT_W'(slc_pkg::MAX_SHARDS) : active_q;

endmodule

>>> sv/sharded_live_task_counter.sv
// Sharded live-task counter.
// Items arrive on req (opcode, primary_shard, fallback_shard) with a
// valid/ready handshake; each item yields exactly one item on rsp carrying
// status, was_last_task, live_total, any_live and fatal_seen.
// The per-shard counts live in a 64-entry synchronous RAM with a registered
// read. A note-live or note-dead item is one read-modify-write of that RAM:
// accept, read, then update and load the result register. A query walks the
// RAM one shard per cycle over the first N shards, N being active_shard_count
// capped at 64, and its result is offered once the walk ends. req is ready
// only while the sequencer is idle, so a new item is taken only after the
// last one has loaded its result.
// The result sits in an output register; if rsp stalls with a result still
// pending, the next finished item waits in its last state until the
// register frees up. No result is dropped or repeated.
// Reset clears the valid bits of the count RAM (all counts read as zero at
// once, no clearing pass), the non-empty count, the fatal flag and the
// active_shard_count register. Configuration goes through the APB port,
// register active_shard_count at address 0; the user must write it only while idle, which the block does not enforce.
module sharded_live_task_counter (
	input  logic                            clk,
	input  logic                            arst_n,
	slc_req_if.sink                         req,
	slc_rsp_if.source                       rsp,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [slc_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [slc_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [slc_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);

	localparam logic [slc_pkg::COUNT_W-1:0] CNT_FULL = '1;

	slc_pkg::state_t state_q, state_d;

	logic [slc_pkg::ACT_W-1:0]   act_eff;
	logic                        accept;
	slc_pkg::op_t                op_in;
	logic                        live_rej_in;
	logic [7:0]                  dead_sel;
	logic [slc_pkg::SHARD_W-1:0] dead_shard;

	// Item registers
	slc_pkg::op_t                op_s1;
	logic [slc_pkg::SHARD_W-1:0] shard_s1;
	logic                        rej_s1;

	// Count RAM
	logic [slc_pkg::COUNT_W-1:0]  cnt_mem [slc_pkg::MAX_SHARDS];
	logic [slc_pkg::MAX_SHARDS-1:0] valid_q;
	logic                         rd_en;
	logic [slc_pkg::SHARD_W-1:0]  rd_addr;
	logic [slc_pkg::COUNT_W-1:0]  rd_data_q;
	logic                         rd_hit_q;
	logic [slc_pkg::COUNT_W-1:0]  cnt;
	logic                         wr_en;
	logic [slc_pkg::COUNT_W-1:0]  wr_data;

	// Scalar state
	logic [slc_pkg::ACT_W-1:0] nonempty_q, nonempty_d;
	logic                      fatal_q, fatal_d;

	// Query walk
	logic [slc_pkg::ACT_W-1:0]   idx_q;
	logic [slc_pkg::ACT_W-1:0]   idx_next;
	logic [slc_pkg::TOTAL_W-1:0] acc_q;
	logic [slc_pkg::TOTAL_W:0]   sum_wide;
	logic [slc_pkg::TOTAL_W-1:0] acc_d;
	logic                        acc_en;

	// Result register
	logic                        rsp_valid_q;
	logic                        out_free;
	logic                        out_load;
	slc_pkg::status_t            status_d;
	logic                        last_d;
	logic [slc_pkg::TOTAL_W-1:0] total_d;
	logic [1:0]                  status_q;
	logic                        last_q;
	logic [slc_pkg::TOTAL_W-1:0] total_q;
	logic                        any_q;
	logic                        fatal_out_q;

	slc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.act_eff (act_eff)
	);

	// Decode the incoming item
	assign op_in  = slc_pkg::op_t'(req.opcode);
	assign accept = req.valid && req.ready;
	assign live_rej_in = ({1'b0, act_eff} <= req.primary_shard);
	assign dead_sel = ({1'b0, act_eff} > req.primary_shard) ?
		req.primary_shard : req.fallback_shard;
	assign dead_shard = ({1'b0, act_eff} > dead_sel) ?
		dead_sel[slc_pkg::SHARD_W-1:0] : '0;

	// Capture the item on accept
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op_in;
			case (op_in)
				slc_pkg::OP_LIVE: begin
					shard_s1 <= req.primary_shard[slc_pkg::SHARD_W-1:0];
					rej_s1   <= (act_eff == '0) || live_rej_in;
				end
				slc_pkg::OP_DEAD: begin
					shard_s1 <= dead_shard;
					rej_s1   <= (act_eff == '0);
				end
				slc_pkg::OP_QUERY: begin
					shard_s1 <= '0;
					rej_s1   <= 1'b0;
				end
				default: begin
					shard_s1 <= '0;
					rej_s1   <= 1'b1;
				end
			endcase
		end
	end

	// Read the RAM, write it back
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= cnt_mem[rd_addr];
		end
		if (wr_en) begin
			cnt_mem[shard_s1] <= wr_data;
		end
	end

	// Track written entries; unwritten ones read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_hit_q <= valid_q[rd_addr];
			end
			if (wr_en) begin
				valid_q[shard_s1] <= 1'b1;
			end
		end
	end

	assign cnt = rd_hit_q ? rd_data_q : '0;

	// Saturating accumulate for the query walk
	assign idx_next = idx_q + 1'b1;
	always_comb begin
		sum_wide = {1'b0, acc_q} + {1'b0, cnt};
		if (idx_q < act_eff) begin
			acc_d = sum_wide[slc_pkg::TOTAL_W] ? '1 : sum_wide[slc_pkg::TOTAL_W-1:0];
		end else begin
			acc_d = acc_q;
		end
	end

	assign out_free = !rsp_valid_q || rsp.ready;

	// Sequence items and compute the update
	always_comb begin
		state_d    = state_q;
		req.ready  = (state_q == slc_pkg::S_IDLE);
		rd_en      = 1'b0;
		rd_addr    = '0;
		wr_en      = 1'b0;
		wr_data    = '0;
		nonempty_d = nonempty_q;
		fatal_d    = fatal_q;
		status_d   = slc_pkg::ST_OK;
		last_d     = 1'b0;
		total_d    = '0;
		out_load   = 1'b0;
		acc_en     = 1'b0;

		case (state_q)
			slc_pkg::S_IDLE: begin
				if (req.valid) begin
					rd_en = 1'b1;
					case (op_in)
						slc_pkg::OP_LIVE:  rd_addr = req.primary_shard[slc_pkg::SHARD_W-1:0];
						slc_pkg::OP_DEAD:  rd_addr = dead_shard;
						default:           rd_addr = '0;
					endcase
					state_d = (op_in == slc_pkg::OP_QUERY) ? slc_pkg::S_QUERY :
						slc_pkg::S_UPDATE;
				end
			end

			slc_pkg::S_UPDATE: begin
				if (rej_s1) begin
					status_d = slc_pkg::ST_REJECT;
				end else if (op_s1 == slc_pkg::OP_LIVE) begin
					if (cnt == CNT_FULL) begin
						status_d = slc_pkg::ST_SATURATED;
					end else begin
						wr_en   = 1'b1;
						wr_data = cnt + 1'b1;
						if (cnt == '0) begin
							nonempty_d = nonempty_q + 1'b1;
						end
					end
				end else begin
					if (cnt == '0) begin
						fatal_d  = 1'b1;
						status_d = slc_pkg::ST_UNDERFLOW;
					end else if (cnt != slc_pkg::COUNT_W'(1)) begin
						wr_en   = 1'b1;
						wr_data = cnt - 1'b1;
					end else if (nonempty_q == '0) begin
						fatal_d  = 1'b1;
						status_d = slc_pkg::ST_UNDERFLOW;
					end else begin
						wr_en      = 1'b1;
						wr_data    = '0;
						nonempty_d = nonempty_q - 1'b1;
						last_d     = (nonempty_q == slc_pkg::ACT_W'(1));
					end
				end
				// Commit only when the result register can take it
				if (out_free) begin
					out_load = 1'b1;
					state_d  = slc_pkg::S_IDLE;
				end else begin
					wr_en      = 1'b0;
					nonempty_d = nonempty_q;
					fatal_d    = fatal_q;
				end
			end

			slc_pkg::S_QUERY: begin
				total_d = acc_d;
				if (idx_next < act_eff) begin
					rd_en   = 1'b1;
					rd_addr = idx_next[slc_pkg::SHARD_W-1:0];
					acc_en  = 1'b1;
				end else if (out_free) begin
					out_load = 1'b1;
					state_d  = slc_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = slc_pkg::S_IDLE;
			end
		endcase
	end

	// Advance the sequencer and scalar state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= slc_pkg::S_IDLE;
			nonempty_q <= '0;
			fatal_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			nonempty_q <= nonempty_d;
			fatal_q    <= fatal_d;
		end
	end

	// Step the query walk
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= '0;
			acc_q <= '0;
		end else if (acc_en) begin
			idx_q <= idx_next;
			acc_q <= acc_d;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q    <= status_d;
			last_q      <= last_d;
			total_q     <= total_d;
			any_q       <= (nonempty_d != '0);
			fatal_out_q <= fatal_d;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.was_last_task = last_q;
	assign rsp.live_total    = total_q;
	assign rsp.any_live      = any_q;
	assign rsp.fatal_seen    = fatal_out_q;

endmodule

>>> dv/testbench.sv
module testbench;

	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned PHASE_ITEMS = 160;

	typedef struct packed {
		slc_pkg::status_t status;
		logic             was_last;
		logic [31:0]      total;
		logic             any_live;
		logic             fatal;
	} reply_t;

	// Shard-count predictor: mirrors the counters and queues one reply per request
	class live_count_predictor;
		bit [slc_pkg::COUNT_W-1:0] shard_count [slc_pkg::MAX_SHARDS];
		bit [slc_pkg::ACT_W-1:0]   nonempty;
		bit                        fatal;
		bit [slc_pkg::ACT_W-1:0]   active_reg;
		reply_t                    awaited [$];
		int unsigned               mismatches;
		int unsigned               replies;
		int unsigned               by_status [4];
		int unsigned               last_tasks;
		int unsigned               queries;

		function int unsigned effective();
			return (active_reg > slc_pkg::MAX_SHARDS) ? slc_pkg::MAX_SHARDS : active_reg;
		endfunction

		function void set_active(bit [slc_pkg::ACT_W-1:0] value);
			active_reg = value;
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction

		// True while some shard inside the active range still holds tasks
		function bit any_in_range();
			int unsigned eff;
			eff = effective();
			for (int i = 0; i < eff; i++)
				if (shard_count[i] != 0)
					return 1'b1;
			return 1'b0;
		endfunction

		// Pick an active shard that holds tasks, or a random shard number if none does
		function bit [7:0] busy_shard();
			int unsigned eff;
			bit [7:0]    picks [$];
			eff = effective();
			for (int i = 0; i < eff; i++)
				if (shard_count[i] != 0)
					picks.push_back(8'(i));
			if (picks.size() == 0)
				return 8'($urandom_range(0, 255));
			return picks[$urandom_range(0, picks.size() - 1)];
		endfunction

		function void note_error(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%s", msg);
		endfunction

		// Advance the counters for one accepted request and queue its reply
		function void apply_request(slc_pkg::op_t op, bit [7:0] prim, bit [7:0] fall);
			reply_t          r;
			int unsigned     eff;
			int unsigned     s;
			longint unsigned sum;
			eff = effective();
			r = '0;
			case (op)
				slc_pkg::OP_LIVE: begin
					if (eff == 0 || prim >= eff)
						r.status = slc_pkg::ST_REJECT;
					else if (shard_count[prim] == '1)
						r.status = slc_pkg::ST_SATURATED;
					else begin
						shard_count[prim] += 1;
						if (shard_count[prim] == 1)
							nonempty++;
					end
				end
				slc_pkg::OP_DEAD: begin
					if (eff == 0)
						r.status = slc_pkg::ST_REJECT;
					else begin
						s = (prim < eff) ? 32'(prim) : 32'(fall);
						if (s >= eff)
							s = 0;
						if (shard_count[s] == 0) begin
							fatal = 1'b1;
							r.status = slc_pkg::ST_UNDERFLOW;
						end else if (shard_count[s] != 1)
							shard_count[s] -= 1;
						else if (nonempty == 0) begin
							// Inconsistent non-empty count: keep the shard at one
							fatal = 1'b1;
							r.status = slc_pkg::ST_UNDERFLOW;
						end else begin
							shard_count[s] = 0;
							nonempty--;
							r.was_last = (nonempty == 0);
						end
					end
				end
				slc_pkg::OP_QUERY: begin
					sum = 0;
					for (int i = 0; i < eff; i++) begin
						sum += shard_count[i];
						if (sum > 64'hFFFF_FFFF) begin
							sum = 64'hFFFF_FFFF;
							break;
						end
					end
					r.total = sum[31:0];
					queries++;
				end
				default: r.status = slc_pkg::ST_REJECT;
			endcase
			r.any_live = (nonempty != 0);
			r.fatal = fatal;
			by_status[r.status]++;
			if (r.was_last)
				last_tasks++;
			awaited.push_back(r);
		endfunction

		// Compare one reply with the oldest queued one
		function void check_reply(reply_t got);
			reply_t want;
			replies++;
			if (awaited.size() == 0) begin
				note_error($sformatf("reply %0d with no request pending: status %0d total %0d",
					replies, got.status, got.total));
				return;
			end
			want = awaited.pop_front();
			if (got !== want)
				note_error($sformatf({"reply %0d: expected status %0d last %0d total %0d any %0d ",
					"fatal %0d, got status %0d last %0d total %0d any %0d fatal %0d"},
					replies, want.status, want.was_last, want.total, want.any_live, want.fatal,
					got.status, got.was_last, got.total, got.any_live, got.fatal));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [slc_pkg::APB_ADDR_W-1:0] paddr;
	logic [slc_pkg::APB_DATA_W-1:0] pwdata;
	logic [slc_pkg::APB_DATA_W-1:0] prdata;
	logic        pready;

	slc_req_if req_ch ();
	slc_rsp_if rsp_ch ();

	live_count_predictor shard_pred;
	reply_t       observed;
	int unsigned  n_sent;
	int unsigned  n_settings;
	int unsigned  burst_left;
	int unsigned  cycles;
	int unsigned  rx_mode;
	int unsigned  rx_mode_left;
	int unsigned  rx_stall_left;
	int unsigned  phase_acts [9] = '{64, 1, 7, 127, 2, 33, 0, 64, 16};

	sharded_live_task_counter u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stop a hung run
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d replies still awaited", cycles,
			shard_pred.pending());
		$display("testbench: errors");
		$finish;
	end

	// Receiver: switch between always ready, coin-flip ready and long stalls
	initial begin
		rsp_ch.ready = 1'b0;
		rx_mode = 0;
		rx_mode_left = 0;
		rx_stall_left = 0;
		forever begin
			@(negedge clk);
			if (rx_mode_left == 0) begin
				rx_mode = $urandom_range(0, 2);
				rx_mode_left = $urandom_range(20, 150);
			end else
				rx_mode_left--;
			case (rx_mode)
				0: rsp_ch.ready = 1'b1;
				1: rsp_ch.ready = 1'($urandom_range(0, 1));
				default: begin
					if (rx_stall_left > 0) begin
						rsp_ch.ready = 1'b0;
						rx_stall_left--;
					end else begin
						rsp_ch.ready = 1'b1;
						rx_stall_left = $urandom_range(1, 12);
					end
				end
			endcase
		end
	end

	// Check every reply taken by the receiver
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			observed.status = slc_pkg::status_t'(rsp_ch.status);
			observed.was_last = rsp_ch.was_last_task;
			observed.total = rsp_ch.live_total;
			observed.any_live = rsp_ch.any_live;
			observed.fatal = rsp_ch.fatal_seen;
			shard_pred.check_reply(observed);
		end
	end

	// One APB transfer: setup cycle, access cycle, then release
	task automatic apb_access(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = slc_pkg::REG_ACTIVE_SHARD_COUNT;
		pwdata = wdata;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Write the active shard count with random upper bits, then read it back
	task automatic set_active_count(input bit [6:0] value);
		logic [31:0] wd;
		logic [31:0] rd;
		wd = $urandom;
		wd[6:0] = value;
		apb_access(1'b1, wd, rd);
		shard_pred.set_active(value);
		apb_access(1'b0, $urandom, rd);
		if (rd[6:0] !== value)
			shard_pred.note_error($sformatf("active_shard_count read back %0d, wrote %0d",
				rd[6:0], value));
		n_settings++;
	endtask

	// Present one item, hold it until taken, then maybe idle between bursts
	task automatic send_item(input slc_pkg::op_t op, input bit [7:0] prim,
		input bit [7:0] fall);
		int unsigned gap;
		@(negedge clk);
		req_ch.valid = 1'b1;
		req_ch.opcode = op;
		req_ch.primary_shard = prim;
		req_ch.fallback_shard = fall;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		shard_pred.apply_request(op, prim, fall);
		n_sent++;
		if (burst_left > 0)
			burst_left--;
		else begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 12);
			gap = $urandom_range(1, 6);
			@(negedge clk);
			req_ch.valid = 1'b0;
			repeat (gap - 1)
				@(negedge clk);
		end
	endtask

	// Drop valid and wait until every reply is back
	task automatic wait_idle();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (shard_pred.pending() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	// Note-live mostly on an active shard, sometimes on any shard
	task automatic random_live();
		int unsigned eff;
		eff = shard_pred.effective();
		if (eff == 0 || $urandom_range(0, 99) < 15)
			send_item(slc_pkg::OP_LIVE, 8'($urandom), 8'($urandom));
		else
			send_item(slc_pkg::OP_LIVE, 8'($urandom_range(0, eff - 1)), 8'($urandom));
	endtask

	// Note-dead on a busy shard, directly or through the fallback, or at random
	task automatic random_dead();
		int unsigned eff;
		int unsigned pick;
		eff = shard_pred.effective();
		pick = $urandom_range(0, 99);
		if (pick < 60)
			send_item(slc_pkg::OP_DEAD, shard_pred.busy_shard(), 8'($urandom));
		else if (pick < 80)
			send_item(slc_pkg::OP_DEAD, 8'($urandom_range(eff > 255 ? 255 : eff, 255)),
				shard_pred.busy_shard());
		else
			send_item(slc_pkg::OP_DEAD, 8'($urandom), 8'($urandom));
	endtask

	// A batch of tasks goes live, then dies off, with queries and noise mixed in
	task automatic run_episode();
		int unsigned k;
		int unsigned steps;
		k = $urandom_range(1, 8);
		repeat (k) begin
			if ($urandom_range(0, 4) == 0)
				send_item(slc_pkg::OP_QUERY, 8'($urandom), 8'($urandom));
			random_live();
		end
		steps = 0;
		do begin
			random_dead();
			steps++;
		end while (shard_pred.any_in_range() && steps < 2 * k + 8);
		if ($urandom_range(0, 1) == 1)
			send_item(slc_pkg::OP_QUERY, 8'($urandom), 8'($urandom));
		if ($urandom_range(0, 9) == 0)
			send_item(slc_pkg::OP_RSVD, 8'($urandom), 8'($urandom));
	endtask

	initial begin
		int unsigned start;
		shard_pred = new();
		n_sent = 0;
		n_settings = 0;
		burst_left = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.opcode = slc_pkg::OP_LIVE;
		req_ch.primary_shard = '0;
		req_ch.fallback_shard = '0;
		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// No active shards: updates are rejected, query reads zero
		send_item(slc_pkg::OP_LIVE, 8'd0, 8'd0);
		send_item(slc_pkg::OP_DEAD, 8'd0, 8'd0);
		send_item(slc_pkg::OP_QUERY, 8'd0, 8'd0);
		send_item(slc_pkg::OP_RSVD, 8'd0, 8'd0);
		wait_idle();

		// Full range: edge shards, out-of-range lives, fallback and shard-zero routing
		set_active_count(7'd64);
		send_item(slc_pkg::OP_LIVE, 8'd0, 8'd0);
		send_item(slc_pkg::OP_LIVE, 8'd63, 8'd0);
		send_item(slc_pkg::OP_LIVE, 8'd64, 8'd0);
		send_item(slc_pkg::OP_LIVE, 8'd255, 8'd255);
		send_item(slc_pkg::OP_LIVE, 8'd0, 8'd255);
		send_item(slc_pkg::OP_QUERY, 8'd255, 8'd255);
		send_item(slc_pkg::OP_DEAD, 8'd0, 8'd255);
		send_item(slc_pkg::OP_DEAD, 8'd200, 8'd63);
		send_item(slc_pkg::OP_DEAD, 8'd255, 8'd255);
		send_item(slc_pkg::OP_DEAD, 8'd5, 8'd0);
		send_item(slc_pkg::OP_QUERY, 8'd0, 8'd0);
		send_item(slc_pkg::OP_RSVD, 8'd255, 8'd255);
		wait_idle();

		// Shrink the active range: shard 2 stays non-empty but leaves the total
		set_active_count(7'd3);
		send_item(slc_pkg::OP_LIVE, 8'd2, 8'd0);
		send_item(slc_pkg::OP_LIVE, 8'd3, 8'd0);
		wait_idle();
		set_active_count(7'd2);
		send_item(slc_pkg::OP_QUERY, 8'd0, 8'd0);
		send_item(slc_pkg::OP_DEAD, 8'd2, 8'd2);
		wait_idle();

		// Count above the shard limit acts as the full range
		set_active_count(7'd127);
		send_item(slc_pkg::OP_DEAD, 8'd2, 8'd9);
		send_item(slc_pkg::OP_QUERY, 8'd127, 8'd127);
		wait_idle();

		// Random phases over several active counts
		foreach (phase_acts[p]) begin
			set_active_count(7'(phase_acts[p]));
			start = n_sent;
			while (n_sent - start < PHASE_ITEMS)
				run_episode();
			wait_idle();
		end

		repeat (20)
			@(posedge clk);
		$display("%0d items over %0d active-count settings, %0d replies checked",
			n_sent, n_settings, shard_pred.replies);
		$display("ok %0d, rejected %0d, underflow %0d, saturated %0d, last-task %0d, queries %0d",
			shard_pred.by_status[slc_pkg::ST_OK], shard_pred.by_status[slc_pkg::ST_REJECT],
			shard_pred.by_status[slc_pkg::ST_UNDERFLOW],
			shard_pred.by_status[slc_pkg::ST_SATURATED],
			shard_pred.last_tasks, shard_pred.queries);
		if (shard_pred.mismatches == 0 && shard_pred.pending() == 0)
			$display("testbench: clean");
		else begin
			$display("%0d mismatches, %0d replies missing", shard_pred.mismatches,
				shard_pred.pending());
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
